// ===== hdl/dual_lane_splitmix_digest_defines.svh =====
// Assertion macros used by the checker file of the digest block.
`ifndef DUAL_LANE_SPLITMIX_DIGEST_DEFINES_SVH
`define DUAL_LANE_SPLITMIX_DIGEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlsd assertion failed");

`endif

// ===== hdl/dlsd_pkg.sv =====
`default_nettype none

package dlsd_pkg;

  // Mixing constants
  localparam logic [63:0] GOLDEN_STEP  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] GOLDEN_TWICE = 64'(GOLDEN_STEP << 1);
  localparam logic [63:0] MUL_FIRST    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_SECOND   = 64'h94d049bb133111eb;
  localparam logic [63:0] SEED_LOW     = 64'h43504d4154484f50;
  localparam logic [63:0] SEED_HIGH    = 64'h53504d4d00000001;
  localparam int unsigned SHIFT_FIRST  = 30;
  localparam int unsigned SHIFT_SECOND = 27;
  localparam int unsigned SHIFT_FINAL  = 31;

  typedef struct packed {
    logic [63:0] data_word;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } out_item_t;

  // Sequencer states: prepare a lane, three partial products, combine, finish word
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_FIN
  } dlsd_state_e;

  typedef struct packed {
    dlsd_state_e state;
    logic        rnd;   // 0: first multiply round, 1: second
    logic        lane;  // 0: low lane, 1: high lane
  } dlsd_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dlsd_mul32.sv =====
`default_nettype none

// Shared 32x32 multiplier with a registered 64-bit product.
module dlsd_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // Register the full product
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/dlsd_seq.sv =====
`default_nettype none

// Sequencer: walks both lanes through two multiply rounds per word.
module dlsd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                last_i,
  input  logic                out_free_i,
  output dlsd_pkg::dlsd_ctrl_t ctrl_o
);
  import dlsd_pkg::*;

  dlsd_state_e state_q, state_d;
  logic        rnd_q, rnd_d;
  logic        lane_q, lane_d;

  // Hold state, round and lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= 1'b0;
      lane_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      lane_q  <= lane_d;
    end
  end

  // Advance through the steps of one word
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    lane_d  = lane_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_PREP;
          lane_d  = 1'b0;
        end
      end
      ST_PREP: begin
        state_d = ST_MUL_A;
        rnd_d   = 1'b0;
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_MUL_C;
      ST_MUL_C: state_d = ST_MUL_D;
      ST_MUL_D: begin
        if (!rnd_q) begin
          state_d = ST_MUL_A;
          rnd_d   = 1'b1;
        end else if (!lane_q) begin
          state_d = ST_PREP;
          lane_d  = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_i || out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o = '{state: state_q, rnd: rnd_q, lane: lane_q};

endmodule

`default_nettype wire

// ===== hdl/dual_lane_splitmix_digest.sv =====
`default_nettype none

// Two-lane splitmix64 digest over a record of 64-bit words.
//
// Input channel: in_valid_i / in_stall_o with in_item_i (data_word, is_last).
// A transaction is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with out_item_o (digest_low,
// digest_high); one transaction per record, after the word marked last.
//
// Each word is fully absorbed before the next word can be taken: both
// lanes pass through two 64-bit multiplies, each built from three 32x32
// partial products on one shared multiplier (states MUL_A to MUL_D per
// multiply, plus one preparation step per lane, one finishing step and
// the idle state in which the next word is taken).
// The digest is loaded into the output register in the last word's finishing step, once the register is free.
//
// Reset loads both lanes with their seeds and empties the output register.
// The output register holds a digest while the receiver stalls; the next
// word is still taken, and only a second digest waits in its finishing step
// until the register frees up.
module dual_lane_splitmix_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlsd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlsd_pkg::out_item_t out_item_o
);
  import dlsd_pkg::*;

  dlsd_ctrl_t  ctrl;
  logic        start;
  logic        out_free;
  logic        emit;
  logic [63:0] word_q;
  logic        last_q;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] low_q, low_d;
  logic [63:0] high_q, high_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  logic [63:0] mconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] prep_sum;
  logic [63:0] prod_sum;
  logic [63:0] lane_res;

  assign start    = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (ctrl.state == ST_FIN) && last_q && out_free;

  dlsd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .last_i     (last_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Select the partial product operands
  assign mconst = ctrl.rnd ? MUL_SECOND : MUL_FIRST;

  always_comb begin
    unique case (ctrl.state)
      ST_MUL_B: begin
        mul_a = x_q[31:0];
        mul_b = mconst[63:32];
      end
      ST_MUL_C: begin
        mul_a = x_q[63:32];
        mul_b = mconst[31:0];
      end
      default: begin
        mul_a = x_q[31:0];
        mul_b = mconst[31:0];
      end
    endcase
  end

  dlsd_mul32 u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Lane input plus golden step; the high lane adds it twice
  assign prep_sum = ctrl.lane ? (high_q + word_q + GOLDEN_TWICE)
                              : ((low_q ^ word_q) + GOLDEN_STEP);
  assign prod_sum = acc_q + {prod[31:0], 32'h0};
  assign lane_res = prod_sum ^ (prod_sum >> SHIFT_FINAL);

  // Working value and partial product accumulator
  always_comb begin
    x_d   = x_q;
    acc_d = acc_q;
    unique case (ctrl.state)
      ST_PREP:  x_d   = prep_sum ^ (prep_sum >> SHIFT_FIRST);
      ST_MUL_B: acc_d = prod;
      ST_MUL_C: acc_d = prod_sum;
      ST_MUL_D: begin
        if (!ctrl.rnd) begin
          x_d = prod_sum ^ (prod_sum >> SHIFT_SECOND);
        end
      end
      default: ;
    endcase
  end

  // Lane updates: write the mixed value, reload seeds on emit
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if ((ctrl.state == ST_MUL_D) && ctrl.rnd) begin
      if (ctrl.lane) begin
        high_d = lane_res;
      end else begin
        low_d = lane_res;
      end
    end else if (emit) begin
      low_d  = SEED_LOW;
      high_d = SEED_HIGH;
    end
  end

  // Output register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= SEED_LOW;
      high_q      <= SEED_HIGH;
      out_valid_q <= 1'b0;
    end else begin
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      word_q <= in_item_i.data_word;
      last_q <= in_item_i.is_last;
    end
    x_q   <= x_d;
    acc_q <= acc_d;
    if (emit) begin
      out_item_q <= '{digest_low: low_q, digest_high: high_q};
    end
  end

  assign in_stall_o  = (ctrl.state != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== hdl/dlsd_checker.sv =====
`default_nettype none

`include "dual_lane_splitmix_digest_defines.svh"

// Port-level checks for the digest block.
module dlsd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dlsd_pkg::out_item_t out_item_o
);

  // A taken word keeps the block busy through its whole absorb sequence
  `DLSD_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `DLSD_ASSERT_IMPL(a_busy_full_span, clk_i, rst_ni, in_valid_i && !in_stall_o, ##19 in_stall_o)

  // A digest only appears out of the finishing step
  `DLSD_ASSERT_IMPL(a_digest_from_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // Hold a stalled digest
  `DLSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

endmodule

bind dual_lane_splitmix_digest dlsd_checker u_dlsd_checker (.*);

`default_nettype wire

// ===== sim/dual_lane_splitmix_digest_tb.sv =====
module dual_lane_splitmix_digest_tb;
  import dlsd_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned DRAIN_EVERY  = 40;

  // Directed words. A digest cannot be read off by eye, so every row goes
  // through the predictor.
  localparam in_item_t DIRECTED_ROWS [0:19] = '{
    // single-word records: zero, all ones, low lane fed zero, high lane fed zero
    '{64'h0000_0000_0000_0000, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 1'b1},
    '{SEED_LOW, 1'b1},
    '{64'(64'd0 - SEED_HIGH - GOLDEN_STEP), 1'b1},
    // multi-word record over the extremes
    '{64'h0000_0000_0000_0000, 1'b0},
    '{64'hffff_ffff_ffff_ffff, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b0},
    '{64'h0000_0000_0000_0001, 1'b1},
    // alternating patterns and a seed value as data
    '{64'h5555_5555_5555_5555, 1'b0},
    '{64'haaaa_aaaa_aaaa_aaaa, 1'b0},
    '{SEED_HIGH, 1'b0},
    '{64'h0000_0000_ffff_ffff, 1'b1},
    // back-to-back single-word records to pile up digests
    '{64'hffff_ffff_0000_0000, 1'b1},
    '{64'h0000_0000_0000_0001, 1'b1},
    '{64'h8000_0000_0000_0000, 1'b1},
    '{64'h0000_0000_0000_0000, 1'b1},
    '{64'hffff_ffff_ffff_ffff, 1'b1},
    // same word repeated within one record
    '{64'h0123_4567_89ab_cdef, 1'b0},
    '{64'h0123_4567_89ab_cdef, 1'b0},
    '{64'h0123_4567_89ab_cdef, 1'b1}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_item     = '0;
  logic      out_stall   = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Driver and stall generator share this: no idling on either side while set
  logic calm = 1'b0;

  logic [63:0] lane_lo = SEED_LOW;
  logic [63:0] lane_hi = SEED_HIGH;
  out_item_t   pending_digests [$];
  out_item_t   want;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_draw  = 0;

  logic in_fire;
  logic out_fire;
  assign in_fire  = in_valid && (in_stall_o === 1'b0);
  assign out_fire = (out_valid_o === 1'b1) && !out_stall;

  dual_lane_splitmix_digest i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // splitmix64 output function on one lane value
  function automatic logic [63:0] splitmix_finalize(input logic [63:0] seed);
    logic [63:0] z;
    z = seed + GOLDEN_STEP;
    z = (z ^ (z >> SHIFT_FIRST)) * MUL_FIRST;
    z = (z ^ (z >> SHIFT_SECOND)) * MUL_SECOND;
    return z ^ (z >> SHIFT_FINAL);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 64'h0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      3: return SEED_LOW ^ 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_record_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 8);
    return $urandom_range(9, 24);
  endfunction

  // Offer one word and hold it until the transaction completes
  task automatic push_word(input logic [63:0] w, input logic last, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_word: w, is_last: last};
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  // Hold off the sender until every pending digest has come out
  task automatic drain_digests();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_digests.size() != 0);
  endtask

  // Fold each accepted word into the predicted lanes; queue a digest on the last word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lane_lo = SEED_LOW;
      lane_hi = SEED_HIGH;
    end else if (in_fire) begin
      lane_lo = splitmix_finalize(lane_lo ^ in_item.data_word);
      lane_hi = splitmix_finalize(lane_hi + in_item.data_word + GOLDEN_STEP);
      if (in_item.is_last) begin
        pending_digests.push_back('{digest_low: lane_lo, digest_high: lane_hi});
        lane_lo = SEED_LOW;
        lane_hi = SEED_HIGH;
      end
    end
  end

  // Compare each output transaction with the oldest pending digest
  always @(posedge clk_i) begin
    if (rst_ni && out_fire) begin
      if (pending_digests.size() == 0) begin
        $display("%0t: digest with none pending: expected none, got low %h high %h",
                 $time, out_item_o.digest_low, out_item_o.digest_high);
        mismatches++;
      end else begin
        want = pending_digests.pop_front();
        if (out_item_o.digest_low !== want.digest_low) begin
          $display("%0t: digest_low expected %h got %h",
                   $time, want.digest_low, out_item_o.digest_low);
          mismatches++;
        end
        if (out_item_o.digest_high !== want.digest_high) begin
          $display("%0t: digest_high expected %h got %h",
                   $time, want.digest_high, out_item_o.digest_high);
          mismatches++;
        end
      end
    end
  end

  // Stall the output side in random runs, none while calm
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_draw = draw_gap();
      out_stall  <= (stall_draw != 0);
      stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if (in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("dual_lane_splitmix_digest verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned words_sent;
    int unsigned records;
    int unsigned rec_len;
    bit          record_calm;
    words_sent = 0;
    records    = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words
    for (int r = 0; r < $size(DIRECTED_ROWS); r++)
      push_word(DIRECTED_ROWS[r].data_word, DIRECTED_ROWS[r].is_last, 1'b0);
    drain_digests();

    // Random records, some with both sides running flat out
    while (words_sent < RANDOM_WORDS) begin
      rec_len     = pick_record_len();
      record_calm = ($urandom_range(0, 99) < 15);
      calm <= record_calm;
      for (int k = 0; k < rec_len; k++)
        push_word(pick_word(), (k == rec_len - 1), record_calm);
      words_sent += rec_len;
      records++;
      if (records % DRAIN_EVERY == 0) drain_digests();
    end

    // Wait out the last digests and a few quiet cycles
    drain_digests();
    calm <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("dual_lane_splitmix_digest verification clean");
    else
      $display("dual_lane_splitmix_digest verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dlsd_pkg.sv
hdl/dlsd_mul32.sv
hdl/dlsd_seq.sv
hdl/dual_lane_splitmix_digest.sv
hdl/dlsd_checker.sv
sim/dual_lane_splitmix_digest_tb.sv
